// File: hdl/ntu_pkg.sv
// Package for the number theory unit: operation codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ntu_pkg;
    typedef enum logic [1:0] {
        FUNC_GCD  = 2'd0,
        FUNC_POW  = 2'd1,
        FUNC_EGCD = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_EU_DIV,
        ST_EU_UPD,
        ST_EU_MUL,
        ST_PW_RED,
        ST_PW_MUL,
        ST_PW_MRED,
        ST_PW_SQR,
        ST_PW_SRED,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

// File: hdl/ntu_if.sv
// Valid/ready channel interfaces for the number theory unit.
// Depends on nothing but the port width parameters.
`timescale 1ns / 1ps
`default_nettype none
interface ntu_in_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [1:0]   func;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface ntu_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        value;
    logic signed [32:0] coeff_x;
    logic signed [32:0] coeff_y;
    modport source (output valid, value, coeff_x, coeff_y, input ready);
    modport sink (input valid, value, coeff_x, coeff_y, output ready);
endinterface
`default_nettype wire

// File: hdl/ntu_divider.sv
// Restoring bit-serial divider: dividend of DW bits by divisor of W bits,
// one quotient bit per cycle. Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none
module ntu_divider #(
    parameter int W  = 32,
    parameter int DW = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [DW-1:0]  dividend,
    input  wire logic [W-1:0]   divisor,
    output logic                busy,
    output logic                done,
    output logic [DW-1:0]       quotient,
    output logic [W-1:0]        remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[W-1:0], quo_reg[DW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[W-1:0];
endmodule
`default_nettype wire

// File: hdl/ntu_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, W by W to 2W bits.
// Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none
module ntu_serial_mul #(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   mcand,
    input  wire logic [W-1:0]   mplier,
    output logic                done,
    output logic [2*W-1:0]      product
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   mc_reg, mc_next, mp_reg, mp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = mcand;
            mp_next   = mplier;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[2*W-2:0], 1'b0}
                       + (mp_reg[W-1] ? {{W{1'b0}}, mc_reg} : '0);
            mp_next  = {mp_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

// File: hdl/number_theory_unit.sv
// Number theory unit: gcd, modular power and extended gcd on a shared
// bit-serial divider and multiplier. Depends on ntu_pkg, ntu_if,
// ntu_divider and ntu_serial_mul.
//
// Usage: an operation enters on the in channel (func, operand_a, operand_b)
// when valid and ready are both high; ready is high only while the unit is
// idle, so one operation is in flight at a time. Its result leaves on the out
// channel as one transaction and is held in an output register until the
// receiver takes it; a stalled receiver keeps the unit from accepting more.
// The modulus register is written through cfg_we and cfg_data; the user must
// do so only while idle, since the block itself does not enforce it. Each
// Euclid step costs one serial division plus, for the extended form, two
// serial multiplies. Modular power costs one base reduction and, per
// exponent bit, up to two multiplies and two reductions. Gcd finishes in
// at most about 1.44 W Euclid steps. Reset clears the control state and
// loads the modulus with 1000000007.
`timescale 1ns / 1ps
`default_nettype none
module number_theory_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    ntu_in_if.sink           in_ch,
    ntu_out_if.source        out_ch
);
    import ntu_pkg::*;
    localparam int W  = OPERAND_WIDTH;
    localparam int CW = W + 2;

    state_t state_reg, state_next;
    logic [31:0]          modulus_reg;
    func_t                func_reg, func_next;
    logic [W-1:0]         r0_reg, r0_next, r1_reg, r1_next;
    logic signed [CW-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic signed [CW-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [W-1:0]         q_reg, q_next;
    logic [W-1:0]         base_reg, base_next, res_reg, res_next;
    logic [W-1:0]         ex_reg, ex_next;
    logic [W-1:0]         mod_w;
    logic                 mod_zero;
    logic                 ov_reg, ov_next;
    logic [31:0]          val_reg, val_next;
    logic signed [32:0]   cx_reg, cx_next, cy_reg, cy_next;

    logic                 div_start, div_busy, div_done;
    logic [2*W-1:0]       div_dividend, div_quot;
    logic [W-1:0]         div_divisor, div_rem;
    logic                 mul_start, mul_done;
    logic [W-1:0]         mul_a, mul_b;
    logic [2*W-1:0]       mul_p;
    logic [1:0]           mul_sel_reg, mul_sel_next;

    assign mod_w    = modulus_reg[W-1:0];
    assign mod_zero = (mod_w == '0);

    ntu_divider #(.W(W), .DW(2*W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_dividend), .divisor(div_divisor),
        .busy(div_busy), .done(div_done),
        .quotient(div_quot), .remainder(div_rem)
    );

    ntu_serial_mul #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .mcand(mul_a), .mplier(mul_b), .done(mul_done), .product(mul_p)
    );

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        r0_next = r0_reg; r1_next = r1_reg;
        s0_next = s0_reg; s1_next = s1_reg;
        t0_next = t0_reg; t1_next = t1_reg;
        q_next = q_reg;
        base_next = base_reg; res_next = res_reg; ex_next = ex_reg;
        ov_next = ov_reg;
        val_next = val_reg; cx_next = cx_reg; cy_next = cy_reg;
        mul_sel_next = mul_sel_reg;
        div_start    = 1'b0;
        div_dividend = {{W{1'b0}}, r0_reg};
        div_divisor  = r1_reg;
        mul_start    = 1'b0;
        mul_a        = base_reg;
        mul_b        = base_reg;
        in_ch.ready  = (state_reg == ST_IDLE) && !ov_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ov_reg && out_ch.ready)
                    ov_next = 1'b0;
                if (in_ch.valid && in_ch.ready)
                begin
                    func_next = func_t'(in_ch.func);
                    r0_next   = in_ch.operand_a;
                    r1_next   = in_ch.operand_b;
                    base_next = in_ch.operand_a;
                    ex_next   = in_ch.operand_b;
                    res_next  = W'(1);
                    s0_next = CW'(1); s1_next = '0;
                    t0_next = '0;     t1_next = CW'(1);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (func_reg)
                    FUNC_GCD, FUNC_EGCD:
                        state_next = ST_EU_DIV;
                    FUNC_POW:
                    begin
                        if (ex_reg == '0)
                            state_next = ST_DONE;
                        else if (mod_zero)
                            state_next = ST_PW_MUL;
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = {{W{1'b0}}, base_reg};
                            div_divisor  = mod_w;
                            state_next   = ST_PW_RED;
                        end
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_EU_DIV:
            begin
                if (r1_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_EU_UPD;
                end
            end
            ST_EU_UPD:
            begin
                if (div_done)
                begin
                    q_next  = div_quot[W-1:0];
                    r0_next = r1_reg;
                    r1_next = div_rem;
                    if (func_reg == FUNC_EGCD)
                    begin
                        mul_start    = 1'b1;
                        mul_a        = div_quot[W-1:0];
                        mul_b        = s1_reg[CW-1] ? W'(-s1_reg) : s1_reg[W-1:0];
                        mul_sel_next = 2'd0;
                        state_next   = ST_EU_MUL;
                    end
                    else
                        state_next = ST_EU_DIV;
                end
            end
            ST_EU_MUL:
            begin
                if (mul_done)
                begin
                    if (mul_sel_reg == 2'd0)
                    begin
                        s0_next = s1_reg;
                        s1_next = s0_reg - (s1_reg[CW-1] ? -CW'(mul_p) : CW'(mul_p));
                        mul_start    = 1'b1;
                        mul_a        = q_reg;
                        mul_b        = t1_reg[CW-1] ? W'(-t1_reg) : t1_reg[W-1:0];
                        mul_sel_next = 2'd1;
                    end
                    else
                    begin
                        t0_next = t1_reg;
                        t1_next = t0_reg - (t1_reg[CW-1] ? -CW'(mul_p) : CW'(mul_p));
                        state_next = ST_EU_DIV;
                    end
                end
            end
            ST_PW_RED:
            begin
                if (div_done)
                begin
                    base_next  = div_rem;
                    state_next = ST_PW_MUL;
                end
            end
            ST_PW_MUL:
            begin
                if (ex_reg == '0)
                    state_next = ST_DONE;
                else if (ex_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = res_reg;
                    mul_b      = base_reg;
                    state_next = ST_PW_MRED;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_PW_SQR;
                end
            end
            ST_PW_MRED:
            begin
                if (mul_done)
                begin
                    if (mod_zero)
                    begin
                        res_next   = mul_p[W-1:0];
                        mul_start  = 1'b1;
                        state_next = ST_PW_SQR;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = mul_p;
                        div_divisor  = mod_w;
                    end
                end
                else if (div_done)
                begin
                    res_next   = div_rem;
                    mul_start  = 1'b1;
                    state_next = ST_PW_SQR;
                end
            end
            ST_PW_SQR:
            begin
                if (mul_done)
                begin
                    if (mod_zero)
                    begin
                        base_next  = mul_p[W-1:0];
                        ex_next    = ex_reg >> 1;
                        state_next = ST_PW_MUL;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = mul_p;
                        div_divisor  = mod_w;
                        state_next   = ST_PW_SRED;
                    end
                end
            end
            ST_PW_SRED:
            begin
                if (div_done)
                begin
                    base_next  = div_rem;
                    ex_next    = ex_reg >> 1;
                    state_next = ST_PW_MUL;
                end
            end
            ST_DONE:
            begin
                val_next = '0; cx_next = '0; cy_next = '0;
                case (func_reg)
                    FUNC_GCD:
                        val_next = 32'(r0_reg);
                    FUNC_EGCD:
                    begin
                        val_next = 32'(r0_reg);
                        cx_next  = 33'(s0_reg);
                        cy_next  = 33'(t0_reg);
                    end
                    FUNC_POW:
                        val_next = 32'(res_reg);
                    default:
                        val_next = '0;
                endcase
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ov_reg      <= 1'b0;
            modulus_reg <= 32'd1000000007;
            mul_sel_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            ov_reg      <= ov_next;
            mul_sel_reg <= mul_sel_next;
            if (cfg_we)
                modulus_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        r0_reg <= r0_next; r1_reg <= r1_next;
        s0_reg <= s0_next; s1_reg <= s1_next;
        t0_reg <= t0_next; t1_reg <= t1_next;
        q_reg <= q_next;
        base_reg <= base_next; res_reg <= res_next; ex_reg <= ex_next;
        val_reg <= val_next; cx_reg <= cx_next; cy_reg <= cy_next;
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.value   = val_reg;
    assign out_ch.coeff_x = cx_reg;
    assign out_ch.coeff_y = cy_reg;

    logic unused_ok;
    assign unused_ok = div_busy ^ (|div_quot[2*W-1:W]);

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE && !out_ch.valid))
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.value)))
        else $error("result dropped");
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == ST_START)
        else $error("accept lost");
endmodule
`default_nettype wire

// File: verif/ntu_checker.sv
// Checker for the number theory unit: watches the configuration port and both
// channels, predicts every result and compares it field by field.
// Depends on ntu_pkg and the channel interfaces in ntu_if.
`timescale 1ns / 1ps
module ntu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    ntu_in_if           in_ch,
    ntu_out_if          out_ch,
    output int          fail_count,
    output int          pending_count
);
    import ntu_pkg::*;

    typedef struct {
        logic [31:0]        value;
        logic signed [32:0] coeff_x;
        logic signed [32:0] coeff_y;
    } ntu_result_t;

    localparam logic [31:0] MODULUS_AT_RESET = 32'd1000000007;

    logic [31:0] modulus_shadow;
    ntu_result_t expected_results[$];

    function automatic logic [63:0] reduce_mod(logic [63:0] v, logic [31:0] m);
        if (m == 32'd0)
        begin
            return v & 64'hFFFF_FFFF;
        end
        return v % {32'd0, m};
    endfunction

    function automatic ntu_result_t compute_result(func_t f, logic [31:0] a,
                                                   logic [31:0] b, logic [31:0] m);
        ntu_result_t r;
        logic [63:0] r0, r1, s0, s1, t0, t1, q, tmp, base, ex, acc;
        r = '{default: '0};
        r0 = {32'd0, a};
        r1 = {32'd0, b};
        case (f)
            FUNC_GCD:
            begin
                while (r1 != 64'd0)
                begin
                    tmp = r0 % r1;
                    r0 = r1;
                    r1 = tmp;
                end
                r.value = r0[31:0];
            end
            FUNC_POW:
            begin
                acc = 64'd1;
                ex = {32'd0, b};
                if (ex != 64'd0)
                begin
                    base = reduce_mod({32'd0, a}, m);
                    while (ex != 64'd0)
                    begin
                        if (ex[0])
                        begin
                            acc = reduce_mod(acc * base, m);
                        end
                        base = reduce_mod(base * base, m);
                        ex = ex >> 1;
                    end
                end
                r.value = acc[31:0];
            end
            FUNC_EGCD:
            begin
                s0 = 64'd1;
                s1 = 64'd0;
                t0 = 64'd0;
                t1 = 64'd1;
                while (r1 != 64'd0)
                begin
                    q = r0 / r1;
                    tmp = r0 - q * r1;
                    r0 = r1;
                    r1 = tmp;
                    tmp = s0 - q * s1;
                    s0 = s1;
                    s1 = tmp;
                    tmp = t0 - q * t1;
                    t0 = t1;
                    t1 = tmp;
                end
                r.value = r0[31:0];
                r.coeff_x = s0[32:0];
                r.coeff_y = t0[32:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic signed [63:0] exp_v,
                                   logic signed [63:0] got_v);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v,
                 got_v);
        fail_count++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        ntu_result_t exp_r;
        if (!rst_n)
        begin
            modulus_shadow <= MODULUS_AT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_shadow <= cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                exp_r = compute_result(func_t'(in_ch.func), in_ch.operand_a,
                                       in_ch.operand_b, modulus_shadow);
                expected_results = {expected_results, exp_r};
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transaction, value", 0, out_ch.value);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.value !== exp_r.value)
                    begin
                        report_mismatch("value", exp_r.value, out_ch.value);
                    end
                    if (out_ch.coeff_x !== exp_r.coeff_x)
                    begin
                        report_mismatch("coeff_x", exp_r.coeff_x, out_ch.coeff_x);
                    end
                    if (out_ch.coeff_y !== exp_r.coeff_y)
                    begin
                        report_mismatch("coeff_y", exp_r.coeff_y, out_ch.coeff_y);
                    end
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
    end
endmodule

// File: verif/tb.sv
// Testbench top for the number theory unit: drives reset, modulus writes and
// operations under varying idle patterns and gives the verdict.
// Depends on ntu_pkg, ntu_if, number_theory_unit and ntu_checker.
`timescale 1ns / 1ps
module tb;
    import ntu_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          stall_cycles;
    int          ops_sent[4];

    ntu_in_if #(.W(32)) in_ch ();
    ntu_out_if out_ch ();

    number_theory_unit #(.OPERAND_WIDTH(32)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    ntu_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(negedge clk)
    begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("number_theory_unit verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_op(func_t f, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.func = f;
        in_ch.operand_a = a;
        in_ch.operand_b = b;
        while (!in_ch.ready)
        begin
            @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid = 1'b0;
        ops_sent[f]++;
    endtask

    task automatic write_modulus(logic [31:0] m);
        wait (pending_count == 0);
        repeat (20) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = m;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return ALL_ONES;
            2: return $urandom_range(255);
            3: return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op();
        func_t f;
        logic [31:0] a;
        logic [31:0] b;
        f = func_t'($urandom_range(9) == 0 ? FUNC_NONE : $urandom_range(2));
        a = pick_operand();
        b = pick_operand();
        if (f == FUNC_POW && $urandom_range(19) != 0)
        begin
            b = $urandom_range(300);
        end
        send_op(f, a, b);
    endtask

    task automatic send_directed();
        send_op(FUNC_GCD, 32'd0, 32'd0);
        send_op(FUNC_GCD, 32'd0, 32'd84);
        send_op(FUNC_GCD, 32'd96, 32'd0);
        send_op(FUNC_GCD, ALL_ONES, ALL_ONES);
        send_op(FUNC_GCD, ALL_ONES, ALL_ONES - 32'd1);
        send_op(FUNC_GCD, 32'd2971215073, 32'd1836311903);
        send_op(FUNC_EGCD, 32'd0, 32'd0);
        send_op(FUNC_EGCD, 32'd0, 32'd5);
        send_op(FUNC_EGCD, 32'd7, 32'd0);
        send_op(FUNC_EGCD, 32'd240, 32'd46);
        send_op(FUNC_EGCD, ALL_ONES, ALL_ONES - 32'd1);
        send_op(FUNC_EGCD, ALL_ONES, 32'd2);
        send_op(FUNC_EGCD, 32'd1836311903, 32'd2971215073);
        send_op(FUNC_POW, 32'd12345, 32'd0);
        send_op(FUNC_POW, 32'd0, 32'd0);
        send_op(FUNC_POW, 32'd0, 32'd5);
        send_op(FUNC_POW, 32'd2, 32'd10);
        send_op(FUNC_POW, ALL_ONES, 32'd1);
        send_op(FUNC_POW, ALL_ONES, ALL_ONES);
        send_op(FUNC_POW, 32'd123456789, 32'd65537);
        send_op(FUNC_NONE, ALL_ONES, ALL_ONES);
        send_op(FUNC_NONE, 32'd0, 32'd0);
    endtask

    initial
    begin
        logic [31:0] moduli[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_GCD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        stall_cycles = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 78;
        moduli = '{32'd1000000007, 32'd1, ALL_ONES, 32'd0, 32'd2, $urandom | 32'd1};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_directed();
        for (int phase = 0; phase < 6; phase++)
        begin
            tx_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 78 : 0;
            rx_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 23 : 0;
            if (phase > 0)
            begin
                write_modulus(moduli[phase]);
            end
            send_op(FUNC_POW, $urandom, 32'd0);
            send_op(FUNC_POW, ALL_ONES, ALL_ONES);
            send_op(FUNC_POW, $urandom, $urandom);
            for (int n = 0; n < 325; n++)
            begin
                send_random_op();
            end
        end
        wait (pending_count == 0);
        repeat (100) @(posedge clk);
        $display("Covered %0d gcd, %0d modular power, %0d extended gcd, %0d unused-code ops",
                 ops_sent[FUNC_GCD], ops_sent[FUNC_POW], ops_sent[FUNC_EGCD],
                 ops_sent[FUNC_NONE]);
        $display("across six modulus settings, including 1, 2, zero and all ones.");
        if (fail_count == 0)
        begin
            $display("number_theory_unit verification clean");
        end
        else
        begin
            $display("number_theory_unit verification failed");
        end
        $finish;
    end
endmodule
